/* src/ecl2eq_pkg.sv */
// ----------------------------------------------------------------------------
// ecl2eq_pkg
// Constants, widths and elaboration-time CORDIC tables for the ecliptic to
// equatorial converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ecl2eq_pkg;

	localparam int CORDIC_STAGES   = 24;
	localparam int ANGLE_FRAC_BITS = 16;
	// Shift from the port format (degrees * 2^F) to degrees * 2^32.
	localparam int ANG_SHIFT       = 32 - ANGLE_FRAC_BITS;

	localparam int LAT_W  = 24;
	localparam int LON_W  = 26;
	localparam int OBL_W  = 23;
	localparam int DEC_W  = 24;
	localparam int RA_W   = 25;
	localparam int RED_W  = 27;               // port-domain angle during reduction
	localparam int AW     = RED_W + ANG_SHIFT; // CORDIC angle, degrees * 2^32
	localparam int VW     = 34;               // vector component, Q30 with headroom
	localparam int PW     = 2 * VW;           // full product width

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 56;
	localparam int PADDR_W     = 2;

	localparam logic [PADDR_W-1:0] REG_OBLIQUITY = 2'd0;
	localparam logic [OBL_W-1:0]   OBLIQ_RESET   = 23'd1535508;

	// Reduction bounds in the port domain.
	localparam logic signed [RED_W-1:0] TURN = RED_W'(360 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [RED_W-1:0] HALF = RED_W'(180 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [RED_W-1:0] QUAR = RED_W'(90 * (1 << ANGLE_FRAC_BITS));

	// Result limits after rounding.
	localparam logic signed [AW:0] DEC_LIM = (AW+1)'(90 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [AW:0] RA_LIM  = (AW+1)'(180 * (1 << ANGLE_FRAC_BITS));

	localparam logic signed [AW-1:0] DEG180 = AW'(64'd180 << 32);
	localparam logic [63:0] RAD_TO_DEG_Q34 = 64'd984333996830;

	// atan(2^-i) in degrees * 2^32; entry 0 is exactly 45 degrees.
	function automatic logic signed [63:0] atan_q32(input int i);
		logic signed [63:0] sum;
		logic signed [63:0] term;
		logic [127:0] prod;
		int e;
		sum = 64'sd0;
		if (i == 0) begin
			return 64'sd45 <<< 32;
		end
		for (int k = 0; k < 63; k++) begin
			e = 62 - i * (2 * k + 1);
			if (e >= 0) begin
				term = signed'((64'd1 << e) / 64'(2 * k + 1));
				if ((k % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		prod = 128'(unsigned'(sum)) * 128'(RAD_TO_DEG_Q34);
		return signed'(prod[127:64]);
	endfunction

	// CORDIC gain in Q31, floor of the square root of the product of stage terms.
	function automatic logic [63:0] gain_q31();
		logic [63:0] p;
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] b;
		p = 64'd1 << 62;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (2 * i < 64) begin
				p = p + (p >> (2 * i));
			end
		end
		n = p;
		res = 64'd0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (b > n) begin
				b = b >> 2;
			end
		end
		for (int j = 0; j < 32; j++) begin
			if (b != 64'd0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	localparam logic [63:0] INV_GAIN_64 = (64'd1 << 61) / gain_q31();
	localparam logic signed [VW-1:0] INV_GAIN = VW'(INV_GAIN_64);

endpackage

`default_nettype wire

/* src/ecliptic_to_equatorial.sv */
// ----------------------------------------------------------------------------
// ecliptic_to_equatorial
// Converts ecliptic latitude/longitude to declination/right ascension with
// pipelined CORDIC rotation and vectoring units.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output is not stalled and
// returns one result per request, in order. Three parallel rotation pipelines
// form the sines and cosines, a short multiplier section rotates the vector by
// the obliquity, and two vectoring pipelines in series produce right ascension
// and declination. The whole pipeline advances whenever the output register is
// empty or being read, so throughput is one item per cycle with no downstream
// stall. The obliquity register must only be written while no request is in
// flight.
`default_nettype none

module ecliptic_to_equatorial
	import ecl2eq_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// [23:0] ecl_latitude, [49:24] ecl_longitude, [55:50] zero
	input  wire logic [IN_TDATA_W-1:0]   s_tdata,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// [23:0] declination, [48:24] right_ascension, [55:49] zero
	output logic [OUT_TDATA_W-1:0]       m_tdata,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [PADDR_W-1:0]      paddr,
	input  wire logic [31:0]             pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int N = CORDIC_STAGES;

	// Reduces a port-domain angle to [-90, 90] degrees; top bit is the flip flag.
	function automatic logic [RED_W:0] reduce(input logic signed [RED_W-1:0] a_in);
		logic signed [RED_W-1:0] a;
		logic flip;
		a = a_in;
		flip = 1'b0;
		if (a >= TURN) begin
			a = a - TURN;
		end else if (a <= -TURN) begin
			a = a + TURN;
		end
		if (a > HALF) begin
			a = a - TURN;
		end else if (a <= -HALF) begin
			a = a + TURN;
		end
		if (a > QUAR) begin
			a = a - HALF;
			flip = 1'b1;
		end else if (a < -QUAR) begin
			a = a + HALF;
			flip = 1'b1;
		end
		return {flip, a};
	endfunction

	function automatic logic signed [RA_W-1:0] to_out(input logic signed [AW-1:0] v,
			input logic signed [AW:0] lim);
		logic signed [AW:0] r;
		r = ((AW+1)'(v) + (AW+1)'(1 << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return RA_W'(r);
	endfunction

	logic en;
	assign en = ~m_tvalid | m_tready;
	assign s_tready = en;

	// Configuration.
	logic [OBL_W-1:0] obliquity_q;
	assign pready = 1'b1;
	assign prdata = (paddr == REG_OBLIQUITY) ? 32'(obliquity_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obliquity_q <= OBLIQ_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_OBLIQUITY) begin
			obliquity_q <= pwdata[OBL_W-1:0];
		end
	end

	// Input reduction.
	logic [RED_W:0] red_lat, red_lon, red_eps;
	assign red_lat = reduce(RED_W'(signed'(s_tdata[LAT_W-1:0])));
	assign red_lon = reduce(RED_W'(signed'(s_tdata[LAT_W+LON_W-1:LAT_W])));
	assign red_eps = reduce(RED_W'({1'b0, obliquity_q}));

	// Rotation pipelines: lane 0 latitude, lane 1 longitude, lane 2 obliquity.
	logic signed [VW-1:0] rot_x_s [3][N+1];
	logic signed [VW-1:0] rot_y_s [3][N+1];
	logic signed [AW-1:0] rot_t_s [3][N+1];
	logic [2:0]           rot_flip_s [N+1];
	logic                 rot_v_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_v_s[0] <= 1'b0;
		end else if (en) begin
			rot_v_s[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_t_s[0][0] <= AW'(signed'(red_lat[RED_W-1:0])) <<< ANG_SHIFT;
			rot_t_s[1][0] <= AW'(signed'(red_lon[RED_W-1:0])) <<< ANG_SHIFT;
			rot_t_s[2][0] <= AW'(signed'(red_eps[RED_W-1:0])) <<< ANG_SHIFT;
			rot_flip_s[0] <= {red_eps[RED_W], red_lon[RED_W], red_lat[RED_W]};
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_rot_in
		always_ff @(posedge clk) begin
			if (en) begin
				rot_x_s[a][0] <= INV_GAIN;
				rot_y_s[a][0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		localparam logic signed [AW-1:0] ATAN_I = AW'(atan_q32(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_v_s[i+1] <= 1'b0;
			end else if (en) begin
				rot_v_s[i+1] <= rot_v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rot_flip_s[i+1] <= rot_flip_s[i];
			end
		end
		for (genvar a = 0; a < 3; a++) begin : g_lane
			always_ff @(posedge clk) begin
				if (en) begin
					if (!rot_t_s[a][i][AW-1]) begin
						rot_x_s[a][i+1] <= rot_x_s[a][i] - (rot_y_s[a][i] >>> i);
						rot_y_s[a][i+1] <= rot_y_s[a][i] + (rot_x_s[a][i] >>> i);
						rot_t_s[a][i+1] <= rot_t_s[a][i] - ATAN_I;
					end else begin
						rot_x_s[a][i+1] <= rot_x_s[a][i] + (rot_y_s[a][i] >>> i);
						rot_y_s[a][i+1] <= rot_y_s[a][i] - (rot_x_s[a][i] >>> i);
						rot_t_s[a][i+1] <= rot_t_s[a][i] + ATAN_I;
					end
				end
			end
		end
	end

	// Unit vectors, then the vector products, then the obliquity rotation.
	logic signed [VW-1:0] cf_s1, sf_s1, cl_s1, sl_s1, ce_s1, se_s1;
	logic signed [VW-1:0] x_s2, y_s2, z_s2, ce_s2, se_s2;
	logic signed [PW-1:0] cy_s3, sz_s3, cz_s3, sy_s3;
	logic signed [VW-1:0] x_s3, x_s4, y2_s4, z2_s4;
	logic                 v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= rot_v_s[N];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cf_s1 <= rot_flip_s[N][0] ? -rot_x_s[0][N] : rot_x_s[0][N];
			sf_s1 <= rot_flip_s[N][0] ? -rot_y_s[0][N] : rot_y_s[0][N];
			cl_s1 <= rot_flip_s[N][1] ? -rot_x_s[1][N] : rot_x_s[1][N];
			sl_s1 <= rot_flip_s[N][1] ? -rot_y_s[1][N] : rot_y_s[1][N];
			ce_s1 <= rot_flip_s[N][2] ? -rot_x_s[2][N] : rot_x_s[2][N];
			se_s1 <= rot_flip_s[N][2] ? -rot_y_s[2][N] : rot_y_s[2][N];

			x_s2  <= VW'((PW'(cf_s1) * PW'(cl_s1)) >>> 30);
			y_s2  <= VW'((PW'(cf_s1) * PW'(sl_s1)) >>> 30);
			z_s2  <= sf_s1;
			ce_s2 <= ce_s1;
			se_s2 <= se_s1;

			cy_s3 <= PW'(ce_s2) * PW'(y_s2);
			sz_s3 <= PW'(se_s2) * PW'(z_s2);
			cz_s3 <= PW'(ce_s2) * PW'(z_s2);
			sy_s3 <= PW'(se_s2) * PW'(y_s2);
			x_s3  <= x_s2;

			y2_s4 <= VW'(((PW+1)'(cy_s3) + (PW+1)'(sz_s3)) >>> 30);
			z2_s4 <= VW'(((PW+1)'(cz_s3) - (PW+1)'(sy_s3)) >>> 30);
			x_s4  <= x_s3;
		end
	end

	// First vectoring pipeline: right ascension = atan2(y', x).
	logic signed [VW-1:0] v1_x_s [N+1];
	logic signed [VW-1:0] v1_y_s [N+1];
	logic signed [AW-1:0] v1_z_s [N+1];
	logic signed [VW-1:0] v1_z2_s [N+1];
	logic                 v1_pole_s [N+1];
	logic                 v1_v_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_v_s[0] <= 1'b0;
		end else if (en) begin
			v1_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1_pole_s[0] <= (x_s4 == '0) && (y2_s4 == '0);
			v1_z2_s[0]   <= z2_s4;
			if (x_s4[VW-1]) begin
				v1_x_s[0] <= -x_s4;
				v1_y_s[0] <= -y2_s4;
				v1_z_s[0] <= y2_s4[VW-1] ? -DEG180 : DEG180;
			end else begin
				v1_x_s[0] <= x_s4;
				v1_y_s[0] <= y2_s4;
				v1_z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec1
		localparam logic signed [AW-1:0] ATAN_I = AW'(atan_q32(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v1_v_s[i+1] <= 1'b0;
			end else if (en) begin
				v1_v_s[i+1] <= v1_v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				v1_pole_s[i+1] <= v1_pole_s[i];
				v1_z2_s[i+1]   <= v1_z2_s[i];
				if (!v1_y_s[i][VW-1]) begin
					v1_x_s[i+1] <= v1_x_s[i] + (v1_y_s[i] >>> i);
					v1_y_s[i+1] <= v1_y_s[i] - (v1_x_s[i] >>> i);
					v1_z_s[i+1] <= v1_z_s[i] + ATAN_I;
				end else begin
					v1_x_s[i+1] <= v1_x_s[i] - (v1_y_s[i] >>> i);
					v1_y_s[i+1] <= v1_y_s[i] + (v1_x_s[i] >>> i);
					v1_z_s[i+1] <= v1_z_s[i] - ATAN_I;
				end
			end
		end
	end

	// Horizontal magnitude with the gain removed.
	logic signed [VW-1:0] r_s5, z2_s5;
	logic signed [AW-1:0] ra_s5;
	logic                 v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v1_v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s5  <= VW'((PW'(v1_x_s[N]) * PW'(INV_GAIN)) >>> 30);
			z2_s5 <= v1_z2_s[N];
			ra_s5 <= v1_pole_s[N] ? '0 : v1_z_s[N];
		end
	end

	// Second vectoring pipeline: declination = atan2(z', r).
	logic signed [VW-1:0] v2_x_s [N+1];
	logic signed [VW-1:0] v2_y_s [N+1];
	logic signed [AW-1:0] v2_z_s [N+1];
	logic signed [AW-1:0] v2_ra_s [N+1];
	logic                 v2_zero_s [N+1];
	logic                 v2_v_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_v_s[0] <= 1'b0;
		end else if (en) begin
			v2_v_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v2_zero_s[0] <= (r_s5 == '0) && (z2_s5 == '0);
			v2_ra_s[0]   <= ra_s5;
			if (r_s5[VW-1]) begin
				v2_x_s[0] <= -r_s5;
				v2_y_s[0] <= -z2_s5;
				v2_z_s[0] <= z2_s5[VW-1] ? -DEG180 : DEG180;
			end else begin
				v2_x_s[0] <= r_s5;
				v2_y_s[0] <= z2_s5;
				v2_z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec2
		localparam logic signed [AW-1:0] ATAN_I = AW'(atan_q32(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v2_v_s[i+1] <= 1'b0;
			end else if (en) begin
				v2_v_s[i+1] <= v2_v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				v2_zero_s[i+1] <= v2_zero_s[i];
				v2_ra_s[i+1]   <= v2_ra_s[i];
				if (!v2_y_s[i][VW-1]) begin
					v2_x_s[i+1] <= v2_x_s[i] + (v2_y_s[i] >>> i);
					v2_y_s[i+1] <= v2_y_s[i] - (v2_x_s[i] >>> i);
					v2_z_s[i+1] <= v2_z_s[i] + ATAN_I;
				end else begin
					v2_x_s[i+1] <= v2_x_s[i] - (v2_y_s[i] >>> i);
					v2_y_s[i+1] <= v2_y_s[i] + (v2_x_s[i] >>> i);
					v2_z_s[i+1] <= v2_z_s[i] - ATAN_I;
				end
			end
		end
	end

	// Output register: rounding and clamping to the result ranges.
	logic signed [AW-1:0] dec_ang;
	logic signed [RA_W-1:0] dec_full;
	logic signed [RA_W-1:0] ra_full;
	assign dec_ang  = v2_zero_s[N] ? '0 : v2_z_s[N];
	assign dec_full = to_out(dec_ang, DEC_LIM);
	assign ra_full  = to_out(v2_ra_s[N], RA_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v2_v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {(OUT_TDATA_W - DEC_W - RA_W)'(0), ra_full, dec_full[DEC_W-1:0]};
		end
	end

endmodule

`default_nettype wire
